// ===== rtl/cokf_pkg.sv =====
// Shared types, codes and the step program of the clock offset/drift Kalman unit.
`timescale 1ns / 1ps
package cokf_pkg;

   localparam logic [1:0] FUNC_PREDICT = 2'd0;
   localparam logic [1:0] FUNC_UPDATE  = 2'd1;
   localparam logic [1:0] FUNC_LOAD    = 2'd2;
   localparam logic [1:0] FUNC_NOP     = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_DT  = 2'd1;
   localparam logic [1:0] STAT_BAD_VAR = 2'd2;

   localparam logic [2:0] CSR_INIT_OFFSET     = 3'd0;
   localparam logic [2:0] CSR_INIT_DRIFT      = 3'd1;
   localparam logic [2:0] CSR_INIT_VAR_OFFSET = 3'd2;
   localparam logic [2:0] CSR_INIT_COV_OD     = 3'd3;
   localparam logic [2:0] CSR_INIT_COV_DO     = 3'd4;
   localparam logic [2:0] CSR_INIT_VAR_DRIFT  = 3'd5;
   localparam logic [2:0] CSR_NOISE_OFFSET    = 3'd6;
   localparam logic [2:0] CSR_NOISE_DRIFT     = 3'd7;

   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

   // program entry points
   localparam logic [5:0] PRED_BASE = 6'd0;
   localparam logic [5:0] UPD_BASE  = 6'd15;
   localparam logic [5:0] LOAD_BASE = 6'd32;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] delta_time;
      logic [63:0] meas_offset;
      logic [63:0] measurement_var;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] offset_estimate;
      logic [63:0] drift_estimate;
      logic [63:0] offset_variance;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL16, OP_MUL32, OP_DIV, OP_LOAD
   } op_type;

   typedef enum logic [4:0] {
      SEL_ZERO, SEL_ONE, SEL_OFF, SEL_DFT, SEL_P00, SEL_P01, SEL_P10, SEL_P11,
      SEL_T0, SEL_T1, SEL_T2, SEL_T3, SEL_T4, SEL_T5,
      SEL_DT, SEL_MEAS, SEL_RVAR, SEL_NOFF, SEL_NDFT
   } sel_type;

   typedef struct packed {
      op_type  op;
      sel_type src_a;
      sel_type src_b;
      sel_type dst;
      logic    last;
   } uop_type;

   typedef struct packed {
      logic       accept;
      logic       start;
      logic       capture;
      uop_type    uop;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       dt_zero;
      logic       rvar_bad;
      logic       op_done;
   } stat_type;

   function automatic uop_type mk(op_type op, sel_type a, sel_type b, sel_type d, logic l);
      uop_type u;
      u.op = op; u.src_a = a; u.src_b = b; u.dst = d; u.last = l;
      return u;
   endfunction

   function automatic uop_type get_uop(logic [5:0] pc);
      uop_type u;
      case (pc)
         // predict
         6'd0:  u = mk(OP_MUL16, SEL_P11,  SEL_DT,   SEL_T0,  1'b0);
         6'd1:  u = mk(OP_ADD,   SEL_P10,  SEL_P01,  SEL_T1,  1'b0);
         6'd2:  u = mk(OP_MUL16, SEL_T1,   SEL_DT,   SEL_T1,  1'b0);
         6'd3:  u = mk(OP_ADD,   SEL_P00,  SEL_T1,   SEL_T1,  1'b0);
         6'd4:  u = mk(OP_MUL16, SEL_T0,   SEL_DT,   SEL_T2,  1'b0);
         6'd5:  u = mk(OP_ADD,   SEL_T1,   SEL_T2,   SEL_T1,  1'b0);
         6'd6:  u = mk(OP_MUL16, SEL_NOFF, SEL_DT,   SEL_T2,  1'b0);
         6'd7:  u = mk(OP_ADD,   SEL_T1,   SEL_T2,   SEL_T1,  1'b0);
         6'd8:  u = mk(OP_MUL16, SEL_DFT,  SEL_DT,   SEL_T2,  1'b0);
         6'd9:  u = mk(OP_ADD,   SEL_OFF,  SEL_T2,   SEL_OFF, 1'b0);
         6'd10: u = mk(OP_ADD,   SEL_P01,  SEL_T0,   SEL_P01, 1'b0);
         6'd11: u = mk(OP_ADD,   SEL_P10,  SEL_T0,   SEL_P10, 1'b0);
         6'd12: u = mk(OP_MUL16, SEL_NDFT, SEL_DT,   SEL_T2,  1'b0);
         6'd13: u = mk(OP_ADD,   SEL_P11,  SEL_T2,   SEL_P11, 1'b0);
         6'd14: u = mk(OP_ADD,   SEL_T1,   SEL_ZERO, SEL_P00, 1'b1);
         // update
         6'd15: u = mk(OP_ADD,   SEL_P00,  SEL_RVAR, SEL_T0,  1'b0);
         6'd16: u = mk(OP_DIV,   SEL_P00,  SEL_T0,   SEL_T1,  1'b0);
         6'd17: u = mk(OP_DIV,   SEL_P10,  SEL_T0,   SEL_T2,  1'b0);
         6'd18: u = mk(OP_SUB,   SEL_MEAS, SEL_OFF,  SEL_T3,  1'b0);
         6'd19: u = mk(OP_SUB,   SEL_ONE,  SEL_T1,   SEL_T0,  1'b0);
         6'd20: u = mk(OP_MUL32, SEL_T0,   SEL_P00,  SEL_T4,  1'b0);
         6'd21: u = mk(OP_MUL32, SEL_T0,   SEL_P01,  SEL_T5,  1'b0);
         6'd22: u = mk(OP_MUL32, SEL_T2,   SEL_P00,  SEL_T0,  1'b0);
         6'd23: u = mk(OP_SUB,   SEL_P10,  SEL_T0,   SEL_P10, 1'b0);
         6'd24: u = mk(OP_MUL32, SEL_T2,   SEL_P01,  SEL_T0,  1'b0);
         6'd25: u = mk(OP_SUB,   SEL_P11,  SEL_T0,   SEL_P11, 1'b0);
         6'd26: u = mk(OP_MUL32, SEL_T1,   SEL_T3,   SEL_T0,  1'b0);
         6'd27: u = mk(OP_ADD,   SEL_OFF,  SEL_T0,   SEL_OFF, 1'b0);
         6'd28: u = mk(OP_MUL32, SEL_T2,   SEL_T3,   SEL_T0,  1'b0);
         6'd29: u = mk(OP_ADD,   SEL_DFT,  SEL_T0,   SEL_DFT, 1'b0);
         6'd30: u = mk(OP_ADD,   SEL_T4,   SEL_ZERO, SEL_P00, 1'b0);
         6'd31: u = mk(OP_ADD,   SEL_T5,   SEL_ZERO, SEL_P01, 1'b1);
         // load
         6'd32: u = mk(OP_LOAD,  SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b1);
         default: u = mk(OP_LOAD, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b1);
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/cokf_dp.sv =====
// Datapath: state, config and temp registers, sequential multiplier and divider.
`timescale 1ns / 1ps
module cokf_dp import cokf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  cmd_type     cmd,
   output stat_type    stat,
   output rsp_type     rsp_data
);

   function automatic logic [63:0] mag(logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? NEG_MIN : POS_MAX;
      return s;
   endfunction

   function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? NEG_MIN : POS_MAX;
      return s;
   endfunction

   function automatic logic [63:0] pack(logic neg, logic hi_nz, logic [63:0] lo);
      if (neg) return (hi_nz || lo > NEG_MIN) ? NEG_MIN : (64'd0 - lo);
      return (hi_nz || lo[63]) ? POS_MAX : lo;
   endfunction

   // configuration
   logic [63:0] init_off_ff, init_dft_ff, init_p00_ff, init_p01_ff, init_p10_ff, init_p11_ff;
   logic [62:0] noise_off_ff, noise_dft_ff;
   // filter state and temps
   logic [63:0] off_ff, dft_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0] t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   // latched input word
   logic [1:0]  func_ff;
   logic [31:0] dt_ff;
   logic [63:0] meas_ff, rvar_ff;
   rsp_type     rsp_ff;

   // multiplier
   logic         mul_busy_ff;
   logic [2:0]   mul_cnt_ff;
   logic [63:0]  ma_ff, mb_ff, prod_ff;
   logic [1:0]   prod_sh_ff;
   logic [127:0] acc_ff, acc_add, acc_shift;
   logic         sh16_ff, neg_ff;
   sel_type      dst_ff;
   logic [63:0]  mul_res;
   // divider
   logic         div_busy_ff, div_pack_ff;
   logic [63:0]  md_ff, rem_ff;
   logic [95:0]  num_ff, quo_ff;
   logic [6:0]   div_cnt_ff;
   logic [64:0]  div_rr;
   logic         div_ge;
   logic [64:0]  div_diff;
   logic [63:0]  div_res;

   logic [63:0] a_val, b_val, wr_data, div_zero_res;
   logic        wr_en, done_ff, done_in;
   sel_type     wr_sel;

   function automatic logic [63:0] rd_sel(sel_type s, logic [63:0] off, logic [63:0] dft,
         logic [63:0] p00, logic [63:0] p01, logic [63:0] p10, logic [63:0] p11,
         logic [63:0] t0, logic [63:0] t1, logic [63:0] t2, logic [63:0] t3,
         logic [63:0] t4, logic [63:0] t5, logic [63:0] dt, logic [63:0] meas,
         logic [63:0] rvar, logic [63:0] noff, logic [63:0] ndft);
      logic [63:0] v;
      case (s)
         SEL_ONE:  v = ONE_Q32;
         SEL_OFF:  v = off;
         SEL_DFT:  v = dft;
         SEL_P00:  v = p00;
         SEL_P01:  v = p01;
         SEL_P10:  v = p10;
         SEL_P11:  v = p11;
         SEL_T0:   v = t0;
         SEL_T1:   v = t1;
         SEL_T2:   v = t2;
         SEL_T3:   v = t3;
         SEL_T4:   v = t4;
         SEL_T5:   v = t5;
         SEL_DT:   v = dt;
         SEL_MEAS: v = meas;
         SEL_RVAR: v = rvar;
         SEL_NOFF: v = noff;
         SEL_NDFT: v = ndft;
         default:  v = 64'd0;
      endcase
      return v;
   endfunction

   always_comb begin
      a_val = rd_sel(cmd.uop.src_a, off_ff, dft_ff, p00_ff, p01_ff, p10_ff, p11_ff,
                     t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, {32'd0, dt_ff}, meas_ff,
                     rvar_ff, {1'b0, noise_off_ff}, {1'b0, noise_dft_ff});
      b_val = rd_sel(cmd.uop.src_b, off_ff, dft_ff, p00_ff, p01_ff, p10_ff, p11_ff,
                     t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, {32'd0, dt_ff}, meas_ff,
                     rvar_ff, {1'b0, noise_off_ff}, {1'b0, noise_dft_ff});
   end

   always_comb begin
      case (prod_sh_ff)
         2'd0:    acc_add = {64'd0, prod_ff};
         2'd1:    acc_add = {32'd0, prod_ff, 32'd0};
         default: acc_add = {prod_ff, 64'd0};
      endcase
      acc_shift = sh16_ff ? (acc_ff >> 16) : (acc_ff >> 32);
      mul_res   = pack(neg_ff, |acc_shift[127:64], acc_shift[63:0]);
      div_rr    = {rem_ff, num_ff[95]};
      div_ge    = div_rr >= {1'b0, md_ff};
      div_diff  = div_rr - {1'b0, md_ff};
      div_res   = pack(neg_ff, |quo_ff[95:64], quo_ff[63:0]);
      if (a_val == 64'd0) div_zero_res = 64'd0;
      else div_zero_res = a_val[63] ? NEG_MIN : POS_MAX;
   end

   // write-back selection
   always_comb begin
      wr_en   = 1'b0;
      wr_sel  = SEL_ZERO;
      wr_data = 64'd0;
      done_in = 1'b0;
      if (cmd.start) begin
         case (cmd.uop.op)
            OP_ADD: begin
               wr_en = 1'b1; wr_sel = cmd.uop.dst; wr_data = sat_add(a_val, b_val);
               done_in = 1'b1;
            end
            OP_SUB: begin
               wr_en = 1'b1; wr_sel = cmd.uop.dst; wr_data = sat_sub(a_val, b_val);
               done_in = 1'b1;
            end
            OP_DIV: begin
               if (b_val == 64'd0) begin
                  wr_en = 1'b1; wr_sel = cmd.uop.dst; wr_data = div_zero_res;
                  done_in = 1'b1;
               end
            end
            OP_LOAD: done_in = 1'b1;
            default: ;
         endcase
      end
      if (mul_busy_ff && mul_cnt_ff == 3'd5) begin
         wr_en = 1'b1; wr_sel = dst_ff; wr_data = mul_res; done_in = 1'b1;
      end
      if (div_pack_ff) begin
         wr_en = 1'b1; wr_sel = dst_ff; wr_data = div_res; done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_off_ff  <= 64'd0;
         init_dft_ff  <= 64'd0;
         init_p00_ff  <= ONE_Q32;
         init_p01_ff  <= 64'd0;
         init_p10_ff  <= 64'd0;
         init_p11_ff  <= ONE_Q32;
         noise_off_ff <= 63'd0;
         noise_dft_ff <= 63'd0;
         off_ff <= 64'd0;
         dft_ff <= 64'd0;
         p00_ff <= ONE_Q32;
         p01_ff <= 64'd0;
         p10_ff <= 64'd0;
         p11_ff <= ONE_Q32;
         mul_busy_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         div_pack_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_INIT_OFFSET:     init_off_ff  <= csr_wdata;
               CSR_INIT_DRIFT:      init_dft_ff  <= csr_wdata;
               CSR_INIT_VAR_OFFSET: init_p00_ff  <= csr_wdata;
               CSR_INIT_COV_OD:     init_p01_ff  <= csr_wdata;
               CSR_INIT_COV_DO:     init_p10_ff  <= csr_wdata;
               CSR_INIT_VAR_DRIFT:  init_p11_ff  <= csr_wdata;
               CSR_NOISE_OFFSET:    noise_off_ff <= csr_wdata[62:0];
               CSR_NOISE_DRIFT:     noise_dft_ff <= csr_wdata[62:0];
               default: ;
            endcase
         end
         if (cmd.start && cmd.uop.op == OP_LOAD) begin
            off_ff <= init_off_ff;
            dft_ff <= init_dft_ff;
            p00_ff <= init_p00_ff;
            p01_ff <= init_p01_ff;
            p10_ff <= init_p10_ff;
            p11_ff <= init_p11_ff;
         end else if (wr_en) begin
            case (wr_sel)
               SEL_OFF: off_ff <= wr_data;
               SEL_DFT: dft_ff <= wr_data;
               SEL_P00: p00_ff <= wr_data;
               SEL_P01: p01_ff <= wr_data;
               SEL_P10: p10_ff <= wr_data;
               SEL_P11: p11_ff <= wr_data;
               default: ;
            endcase
         end
         // unit control
         if (cmd.start && (cmd.uop.op == OP_MUL16 || cmd.uop.op == OP_MUL32)) begin
            mul_busy_ff <= 1'b1;
         end else if (mul_busy_ff && mul_cnt_ff == 3'd5) begin
            mul_busy_ff <= 1'b0;
         end
         div_pack_ff <= 1'b0;
         if (cmd.start && cmd.uop.op == OP_DIV && b_val != 64'd0) begin
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && div_cnt_ff == 7'd95) begin
            div_busy_ff <= 1'b0;
            div_pack_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_sel)
            SEL_T0: t0_ff <= wr_data;
            SEL_T1: t1_ff <= wr_data;
            SEL_T2: t2_ff <= wr_data;
            SEL_T3: t3_ff <= wr_data;
            SEL_T4: t4_ff <= wr_data;
            SEL_T5: t5_ff <= wr_data;
            default: ;
         endcase
      end
      if (cmd.accept) begin
         func_ff <= req_data.func;
         dt_ff   <= req_data.delta_time;
         meas_ff <= req_data.meas_offset;
         rvar_ff <= req_data.measurement_var;
      end
      if (cmd.capture) begin
         rsp_ff <= '{status: cmd.status, offset_estimate: off_ff,
                     drift_estimate: dft_ff, offset_variance: p00_ff};
      end
      if (cmd.start) begin
         dst_ff  <= cmd.uop.dst;
         neg_ff  <= a_val[63] ^ b_val[63];
         sh16_ff <= (cmd.uop.op == OP_MUL16);
      end
      // multiplier: four 32x32 partial products, each added in the cycle after it is formed
      if (cmd.start) begin
         ma_ff      <= mag(a_val);
         mb_ff      <= mag(b_val);
         mul_cnt_ff <= 3'd0;
         acc_ff     <= 128'd0;
      end else if (mul_busy_ff) begin
         mul_cnt_ff <= mul_cnt_ff + 3'd1;
         if (mul_cnt_ff <= 3'd3) begin
            prod_ff <= (mul_cnt_ff[0] ? {32'd0, ma_ff[63:32]} : {32'd0, ma_ff[31:0]})
                     * (mul_cnt_ff[1] ? {32'd0, mb_ff[63:32]} : {32'd0, mb_ff[31:0]});
            prod_sh_ff <= {1'b0, mul_cnt_ff[0]} + {1'b0, mul_cnt_ff[1]};
         end
         if (mul_cnt_ff >= 3'd1 && mul_cnt_ff <= 3'd4) acc_ff <= acc_ff + acc_add;
      end
      // divider: restoring, one quotient bit per cycle
      if (cmd.start) begin
         md_ff      <= mag(b_val);
         num_ff     <= {mag(a_val), 32'd0};
         rem_ff     <= 64'd0;
         quo_ff     <= 96'd0;
         div_cnt_ff <= 7'd0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 7'd1;
         num_ff     <= {num_ff[94:0], 1'b0};
         rem_ff     <= div_ge ? div_diff[63:0] : div_rr[63:0];
         quo_ff     <= {quo_ff[94:0], div_ge};
      end
   end

   assign stat.func     = func_ff;
   assign stat.dt_zero  = (dt_ff == 32'd0);
   assign stat.rvar_bad = rvar_ff[63] || (rvar_ff == 64'd0);
   assign stat.op_done  = done_ff;
   assign rsp_data      = rsp_ff;

endmodule

// ===== rtl/cokf_ctrl.sv =====
// Controller: decodes a request word and steps the datapath through its program.
`timescale 1ns / 1ps
module cokf_ctrl import cokf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_ISSUE  = 5'b00100,
      S_WAIT   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  pc_ff, pc_in;
   logic [1:0]  code_ff, code_in;
   logic        rsp_valid_ff, rsp_valid_in;
   uop_type     uop;

   assign uop = get_uop(pc_ff);

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.accept   = 1'b0;
      cmd.start    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.uop      = uop;
      cmd.status   = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            code_in  = STAT_OK;
            state_in = S_ISSUE;
            case (stat.func)
               FUNC_PREDICT: begin
                  pc_in = PRED_BASE;
                  if (stat.dt_zero) begin
                     code_in  = STAT_BAD_DT;
                     state_in = S_FINISH;
                  end
               end
               FUNC_UPDATE: begin
                  pc_in = UPD_BASE;
                  if (stat.rvar_bad) begin
                     code_in  = STAT_BAD_VAR;
                     state_in = S_FINISH;
                  end
               end
               FUNC_LOAD: pc_in = LOAD_BASE;
               default: state_in = S_FINISH;
            endcase
         end
         S_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (stat.op_done) begin
               if (uop.last) state_in = S_FINISH;
               else begin
                  pc_in    = pc_ff + 6'd1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.capture  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= 6'd0;
         code_ff      <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/clock_offset_drift_kalman_unit.sv =====
// Top level of the two-state clock offset/drift Kalman filter.
`timescale 1ns / 1ps
// Usage:
//  - Request channel (req_valid / req_stall / req_data): one word per filter step.
//    func selects predict (advance by delta_time), update (blend in a measured
//    offset with its variance) or load (copy the init registers into the state).
//  - Response channel (rsp_valid / rsp_stall / rsp_data): one word per request,
//    carrying status and the offset, drift and offset variance after the step.
//  - CSR port (csr_write_en / csr_index / csr_wdata): write the init and noise
//    registers while no request is in flight.
//  - One request is worked on at a time. A controller runs a short program on a
//    datapath with one 32x32 multiplier and a restoring divider that makes one
//    quotient bit per cycle (96 bits). An update is dominated by its two
//    divisions, which are skipped when S is zero; a rejected request or an
//    unused func skips the program and goes straight to the response.
//  - The response sits in an output register; the next request is taken while
//    it waits. If the receiver stalls, a finished step holds until the
//    response is taken, and no response is dropped.
//  - Reset clears the state to offset 0, drift 0, covariance identity and the
//    registers to their defaults; no clearing pass is needed.
module clock_offset_drift_kalman_unit import cokf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: decode, issue program steps, drive the response valid
   cokf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic and the data registers, including the output register
   cokf_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== tb/tb_clock_offset_drift_kalman_unit.sv =====
// Self-checking bench for the clock offset/drift Kalman unit against a fixed-point model.
`timescale 1ns / 1ps
module tb_clock_offset_drift_kalman_unit;
   import cokf_pkg::*;

   // Clock and reset; reset is released once and never raised again.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = CSR_INIT_OFFSET;
   logic [63:0] csr_wdata = '0;

   clock_offset_drift_kalman_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Filter state as the bench tracks it, plus its own copy of the registers.
   logic [63:0] est_off = 64'd0, est_dft = 64'd0, p00 = ONE_Q32, p01 = 64'd0;
   logic [63:0] p10 = 64'd0, p11 = ONE_Q32;
   logic [63:0] init_regs [0:5];
   logic [62:0] q_noff, q_ndft;

   req_type  pending_words [$];
   rsp_type  expected_words [$];
   int       error_count = 0;
   int       idle_cycles = 0;
   bit       quiet_phase = 1'b0;
   bit       long_hold = 1'b0;
   int       words_sent = 0;
   int       words_offered = 0;

   localparam logic signed [64:0] MAX_S = 65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] MIN_S = -65'sh0_8000_0000_0000_0000;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > MAX_S) return POS_MAX;
      if (s < MIN_S) return NEG_MIN;
      return s[63:0];
   endfunction

   function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) - $signed({b[63], b});
      if (s > MAX_S) return POS_MAX;
      if (s < MIN_S) return NEG_MIN;
      return s[63:0];
   endfunction

   // Saturate a sign plus 128-bit magnitude to 64 bits.
   function automatic logic [63:0] clamp_mag(bit neg, logic [127:0] m);
      if (neg) return (m > {64'd0, NEG_MIN}) ? NEG_MIN : (64'd0 - m[63:0]);
      return (m > {64'd0, POS_MAX}) ? POS_MAX : m[63:0];
   endfunction

   function automatic logic [63:0] abs64(logic [63:0] x);
      return x[63] ? 64'd0 - x : x;
   endfunction

   // Signed product, magnitude truncated by sh bits (toward zero), saturated.
   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] m;
      m = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> sh;
      return clamp_mag(a[63] ^ b[63], m);
   endfunction

   // Gain: (n << 32) / d truncating toward zero; zero divisor saturates by sign of n (zero when n is zero).
   function automatic logic [63:0] fx_gain(logic [63:0] n, logic [63:0] d);
      logic [127:0] q;
      if (d == 0) return (n == 0) ? 64'd0 : (n[63] ? NEG_MIN : POS_MAX);
      q = ({64'd0, abs64(n)} << 32) / {64'd0, abs64(d)};
      return clamp_mag(n[63] ^ d[63], q);
   endfunction

   function automatic rsp_type filter_step(req_type w);
      rsp_type r;
      logic [63:0] dt, t0, np00, s, ko, kd, res, om, n00, n01, n10, n11;
      r.status = STAT_OK;
      dt = {32'd0, w.delta_time};
      case (w.func)
         FUNC_PREDICT: begin
            if (w.delta_time == 0) begin
               r.status = STAT_BAD_DT;
            end else begin
               t0 = fx_mul(p11, dt, 16);
               np00 = sat_add(p00, fx_mul(sat_add(p10, p01), dt, 16));
               np00 = sat_add(np00, fx_mul(t0, dt, 16));
               np00 = sat_add(np00, fx_mul({1'b0, q_noff}, dt, 16));
               est_off = sat_add(est_off, fx_mul(est_dft, dt, 16));
               p01 = sat_add(p01, t0);
               p10 = sat_add(p10, t0);
               p11 = sat_add(p11, fx_mul({1'b0, q_ndft}, dt, 16));
               p00 = np00;
            end
         end
         FUNC_UPDATE: begin
            if (w.measurement_var[63] || w.measurement_var == 0) begin
               r.status = STAT_BAD_VAR;
            end else begin
               s   = sat_add(p00, w.measurement_var);
               ko  = fx_gain(p00, s);
               kd  = fx_gain(p10, s);
               res = sat_sub(w.meas_offset, est_off);
               om  = sat_sub(ONE_Q32, ko);
               n00 = fx_mul(om, p00, 32);
               n01 = fx_mul(om, p01, 32);
               n10 = sat_sub(p10, fx_mul(kd, p00, 32));
               n11 = sat_sub(p11, fx_mul(kd, p01, 32));
               est_off = sat_add(est_off, fx_mul(ko, res, 32));
               est_dft = sat_add(est_dft, fx_mul(kd, res, 32));
               p00 = n00; p01 = n01; p10 = n10; p11 = n11;
            end
         end
         FUNC_LOAD: begin
            est_off = init_regs[CSR_INIT_OFFSET]; est_dft = init_regs[CSR_INIT_DRIFT];
            p00 = init_regs[CSR_INIT_VAR_OFFSET]; p01 = init_regs[CSR_INIT_COV_OD];
            p10 = init_regs[CSR_INIT_COV_DO]; p11 = init_regs[CSR_INIT_VAR_DRIFT];
         end
         default: ;
      endcase
      r.offset_estimate = est_off;
      r.drift_estimate  = est_dft;
      r.offset_variance = p00;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: offer the next queued word; bursts of idling except in the quiet phase.
   int send_gap = 0;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_words.push_back(filter_step(req_data));
         words_sent++;
      end
   end

   // A word on the bus is free to change once the accept count has caught up with it.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || words_sent == words_offered) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               words_offered++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random bursts, or one long hold-off while the sender keeps going.
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold && !hold_done && hold_left == 0 && stall_left == 0) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", {62'd0, rsp_data.status}, 64'd0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", {62'd0, rsp_data.status}, {62'd0, want.status});
            if (rsp_data.offset_estimate != want.offset_estimate)
               report_mismatch("offset", rsp_data.offset_estimate, want.offset_estimate);
            if (rsp_data.drift_estimate != want.drift_estimate)
               report_mismatch("drift", rsp_data.drift_estimate, want.drift_estimate);
            if (rsp_data.offset_variance != want.offset_variance)
               report_mismatch("variance", rsp_data.offset_variance, want.offset_variance);
         end
      end
   end

   // Watchdog: count cycles without any handshake and stop with FAIL past a limit.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Register write at a falling edge, for one cycle; mirror it in the bench.
   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_NOISE_OFFSET) q_noff = val[62:0];
      else if (idx == CSR_NOISE_DRIFT) q_ndft = val[62:0];
      else init_regs[idx] = val;
   endtask

   // Wait until every word is sent and answered, then let the block settle.
   task automatic drain;
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Small-to-moderate Q32.32 value, occasionally an extreme.
   function automatic logic [63:0] pick_val();
      case ($urandom_range(0, 9))
         0: return POS_MAX;
         1: return NEG_MIN;
         2: return rand64();
         3: return 64'd0;
         default: return {24'd0, 8'($urandom_range(0, 255)), $urandom()} ^
                         ($urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0);
      endcase
   endfunction

   function automatic req_type pick_word();
      req_type w;
      int k;
      w.delta_time      = ($urandom_range(0, 9) == 0) ? $urandom()
                        : $urandom_range(1, 32'h0004_0000);
      w.meas_offset     = pick_val();
      w.measurement_var = ($urandom_range(0, 7) == 0) ? pick_val()
                        : {24'd0, 8'($urandom_range(1, 255)), $urandom()}
                          >> $urandom_range(0, 8);
      k = $urandom_range(0, 19);
      if (k < 8) w.func = FUNC_PREDICT;
      else if (k < 16) w.func = FUNC_UPDATE;
      else if (k < 19) w.func = FUNC_LOAD;
      else w.func = FUNC_NOP;
      if ($urandom_range(0, 30) == 0) w.delta_time = 0;
      return w;
   endfunction

   function automatic req_type mk_word(logic [1:0] f, logic [31:0] dt, logic [63:0] m,
                                       logic [63:0] rv);
      req_type w;
      w.func = f; w.delta_time = dt; w.meas_offset = m; w.measurement_var = rv;
      return w;
   endfunction

   initial begin
      init_regs[CSR_INIT_OFFSET] = 0; init_regs[CSR_INIT_DRIFT] = 0;
      init_regs[CSR_INIT_VAR_OFFSET] = ONE_Q32;
      init_regs[CSR_INIT_COV_OD] = 0; init_regs[CSR_INIT_COV_DO] = 0;
      init_regs[CSR_INIT_VAR_DRIFT] = ONE_Q32;
      q_noff = 0; q_ndft = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: every func, bad dt, bad variance, extremes, unused func.
      pending_words.push_back(mk_word(FUNC_PREDICT, 32'h0001_0000, 0, 0));
      pending_words.push_back(mk_word(FUNC_PREDICT, 32'd0, 0, 0));
      pending_words.push_back(mk_word(FUNC_UPDATE, 32'd0, 64'h0000_0005_0000_0000, ONE_Q32));
      pending_words.push_back(mk_word(FUNC_UPDATE, 32'd0, ONE_Q32, 64'd0));
      pending_words.push_back(mk_word(FUNC_UPDATE, 32'd0, ONE_Q32, NEG_MIN));
      pending_words.push_back(mk_word(FUNC_UPDATE, 32'hFFFF_FFFF, POS_MAX, POS_MAX));
      pending_words.push_back(mk_word(FUNC_UPDATE, 32'd0, NEG_MIN, 64'd1));
      pending_words.push_back(mk_word(FUNC_PREDICT, 32'hFFFF_FFFF, POS_MAX, 0));
      pending_words.push_back(mk_word(FUNC_PREDICT, 32'd1, 0, 0));
      pending_words.push_back(mk_word(FUNC_NOP, 32'hFFFF_FFFF, POS_MAX, NEG_MIN));
      pending_words.push_back(mk_word(FUNC_LOAD, 32'd0, 0, 0));
      drain();

      // Extreme registers: saturating load, negative covariance and zero S cases.
      write_reg(CSR_INIT_OFFSET, POS_MAX);
      write_reg(CSR_INIT_DRIFT, NEG_MIN);
      write_reg(CSR_INIT_VAR_OFFSET, NEG_MIN);
      write_reg(CSR_INIT_COV_OD, POS_MAX);
      write_reg(CSR_INIT_COV_DO, NEG_MIN);
      write_reg(CSR_INIT_VAR_DRIFT, POS_MAX);
      write_reg(CSR_NOISE_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_NOISE_DRIFT, 64'h7FFF_FFFF_FFFF_FFFF);
      pending_words.push_back(mk_word(FUNC_LOAD, 0, 0, 0));
      pending_words.push_back(mk_word(FUNC_PREDICT, 32'h0002_0000, 0, 0));
      pending_words.push_back(mk_word(FUNC_LOAD, 0, 0, 0));
      pending_words.push_back(mk_word(FUNC_UPDATE, 0, NEG_MIN, 64'd1));
      pending_words.push_back(mk_word(FUNC_LOAD, 0, 0, 0));
      // p00 = NEG_MIN, R = POS_MAX gives S = -1: negative divisor
      pending_words.push_back(mk_word(FUNC_UPDATE, 0, POS_MAX, POS_MAX));
      drain();
      write_reg(CSR_INIT_VAR_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
      pending_words.push_back(mk_word(FUNC_LOAD, 0, 0, 0));
      // p00 = -1, R = 1 makes S zero
      pending_words.push_back(mk_word(FUNC_UPDATE, 0, ONE_Q32, 64'd1));
      drain();

      // Random phases with fresh register settings; moderate values mostly.
      for (int ph = 0; ph < 6; ph++) begin
         for (int r = 0; r < 8; r++)
            write_reg(r[2:0], (ph == 5) ? 64'd0 :
                      (r[2:0] == CSR_INIT_VAR_OFFSET || r[2:0] == CSR_INIT_VAR_DRIFT)
                         ? {28'd0, 4'($urandom_range(1, 15)), $urandom()}
                         : pick_val());
         pending_words.push_back(mk_word(FUNC_LOAD, 0, 0, 0));
         for (int n = 0; n < 85; n++) pending_words.push_back(pick_word());
         if (ph == 1) long_hold = 1'b1;
         if (ph == 5) quiet_phase = 1'b1;
         drain();
      end
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
